// ===== rtl/pwft_pkg.sv =====
`default_nettype none

package pwft_pkg;

    // Parameter defaults handed to the top level.
    localparam int MAX_NEST_DEFAULT    = 64;
    localparam int LENGTH_BITS_DEFAULT = 32;

    // Reset value of the nesting limit register.
    localparam logic [6:0] MAX_NESTING_RESET = 7'd64;

    // Result kinds.
    localparam logic [2:0] KIND_VARINT  = 3'd0;
    localparam logic [2:0] KIND_SIZED   = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_OVERFLOW  = 3'd0;
    localparam logic [2:0] ERR_FIELD_NUM = 3'd1;
    localparam logic [2:0] ERR_WIRE_TYPE = 3'd2;
    localparam logic [2:0] ERR_STRAY_END = 3'd3;
    localparam logic [2:0] ERR_MISMATCH  = 3'd4;
    localparam logic [2:0] ERR_NESTING   = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    // Wire types.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_SGROUP  = 3'd3;
    localparam logic [2:0] WT_EGROUP  = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic [2:0]  error_code;
        logic        last_of_run;
    } out_word_t;

    // Command to the group number stack for one accepted word.
    typedef struct packed {
        logic        clear;
        logic        push;
        logic        pop;
        logic [28:0] num;
    } stk_cmd_t;

    // Writes into the result queue for one accepted word.
    typedef struct packed {
        logic      push0;
        logic      push1;
        out_word_t word0;
        out_word_t word1;
    } outq_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pwft_stack.sv =====
`default_nettype none

module pwft_stack #(
    parameter int MAX_NEST = pwft_pkg::MAX_NEST_DEFAULT,
    parameter int DW       = $clog2(MAX_NEST + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pwft_pkg::stk_cmd_t cmd,
    output logic [DW-1:0]           depth,
    output logic [28:0]             top
);
    import pwft_pkg::*;

    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    // The innermost entry lives in top_reg; the memory holds the entries below
    // it at their own indexes. The entry under the top is prefetched every cycle
    // so that a pop can take it at once.
    logic [28:0]   stack_mem [MAX_NEST];
    logic [DW-1:0] depth_reg, depth_next;
    logic [28:0]   top_reg, top_next;
    logic [28:0]   rd_data_reg;
    logic          byp_reg;
    logic [28:0]   byp_data_reg;
    logic [28:0]   below;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign below   = byp_reg ? byp_data_reg : rd_data_reg;
    assign wr_en   = cmd.push && (depth_reg != '0);
    assign wr_addr = AW'(depth_reg - DW'(1));
    assign rd_addr = AW'(depth_next - DW'(2));

    always_comb begin
        depth_next = depth_reg;
        top_next   = top_reg;
        if (cmd.push) begin
            depth_next = depth_reg + DW'(1);
            top_next   = cmd.num;
        end else if (cmd.pop) begin
            depth_next = depth_reg - DW'(1);
            top_next   = below;
        end
        if (cmd.clear) begin
            depth_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        rd_data_reg  <= stack_mem[rd_addr];
        byp_reg      <= wr_en && (wr_addr == rd_addr);
        byp_data_reg <= top_reg;
        if (wr_en) begin
            stack_mem[wr_addr] <= top_reg;
        end
    end

    assign depth = depth_reg;
    assign top   = top_reg;

endmodule

`default_nettype wire

// ===== rtl/pwft_outq.sv =====
`default_nettype none

module pwft_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pwft_pkg::outq_wr_t  wr,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pwft_pkg::out_word_t      m_data
);
    import pwft_pkg::*;

    // Four-entry queue with two write lanes and one read lane.
    out_word_t  q_mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = q_mem[rp_reg];
    assign room    = (count_reg <= 3'd2);

    always_comb begin
        count_next = count_reg + 3'(wr.push0) + 3'(wr.push1) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_reg + 2'(wr.push0) + 2'(wr.push1);
            rp_reg    <= rp_reg + 2'(pop);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push0) begin
            q_mem[wp_reg] <= wr.word0;
        end
        if (wr.push1) begin
            q_mem[wp_reg + 2'd1] <= wr.word1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/protobuf_wire_field_tokenizer.sv =====
`default_nettype none

// Streaming tokenizer for the protobuf wire format. One word of the input
// channel is one message byte plus a flag on the final byte of the message.
// The block takes one byte per cycle while the result queue has room: every
// key, varint, length and payload byte is decoded in the cycle it is
// accepted, and its records enter a four-entry result queue at the next
// clock edge. A byte gives at most two records (a field record followed by
// a message end or a truncation error); the input stays ready while the
// queue holds two or fewer records, so with a result side that is always
// ready the rate is one byte per cycle, but bytes that yield two records can
// fill the queue and stall the input. Group numbers are kept on a stack whose
// innermost entry sits in a register while the deeper entries sit in a
// synchronous memory; the entry beneath the top is read ahead every cycle,
// with write-to-read forwarding, so a group end can be checked and popped on
// any byte, also right after a push or pop. Payload bytes and field records
// are emitted only outside groups; a group gives one record when its
// outermost level closes. After an error, bytes are dropped until the final
// byte of the message, which gives a message end record. The nesting limit
// register may be written only while the block is idle.
module protobuf_wire_field_tokenizer #(
    parameter int MAX_NEST    = pwft_pkg::MAX_NEST_DEFAULT,
    parameter int LENGTH_BITS = pwft_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [6:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pwft_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pwft_pkg::out_word_t      m_data
);
    import pwft_pkg::*;

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int CW = (DW > 7) ? DW : 7;

    // Parse phases.
    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_BYTES = 2'd2;

    logic [6:0]             max_nesting_reg;
    logic [1:0]             phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic [3:0]             shift_reg, shift_next;
    logic [28:0]            hfn_reg, hfn_next;
    logic [2:0]             hwt_reg, hwt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   latched_reg, latched_next;

    logic                   accept;
    logic                   room;
    logic [DW-1:0]          depth;
    logic [DW-1:0]          depth_after;
    logic [28:0]            top;
    logic [CW-1:0]          limit;
    logic [5:0]             shamt;
    logic [63:0]            acc_new;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   err_valid;
    logic [2:0]             err_code;
    logic                   rec_valid;
    out_word_t              rec;
    out_word_t              tail;
    logic                   tail_valid;
    stk_cmd_t               cmd;
    outq_wr_t               wr;

    assign accept  = s_valid && s_ready;
    assign s_ready = room;

    // The limit in force is the smaller of the register and the stack capacity.
    assign limit = (CW'(max_nesting_reg) < CW'(MAX_NEST)) ? CW'(max_nesting_reg)
                                                         : CW'(MAX_NEST);

    // Seven bits per varint byte; the position never passes nine.
    assign shamt   = 6'({3'b000, shift_reg} << 3) - 6'({2'b00, shift_reg});
    assign acc_new = acc_reg | (64'(s_data.data_byte[6:0]) << shamt);
    assign rem_dec = rem_reg - LENGTH_BITS'(1);

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        shift_next   = shift_reg;
        hfn_next     = hfn_reg;
        hwt_next     = hwt_reg;
        rem_next     = rem_reg;
        latched_next = latched_reg;
        err_valid    = 1'b0;
        err_code     = ERR_OVERFLOW;
        rec_valid    = 1'b0;
        rec          = '0;
        tail         = '0;
        tail_valid   = 1'b0;
        depth_after  = depth;
        cmd          = '0;
        cmd.num      = acc_new[31:3];

        if (latched_reg) begin
            if (s_data.end_of_message) begin
                tail_valid = 1'b1;
                tail.kind  = KIND_END;
            end
        end else begin
            if (phase_reg == PH_BYTES) begin
                if (depth == '0) begin
                    rec_valid         = 1'b1;
                    rec.kind          = KIND_PAYLOAD;
                    rec.field_number  = hfn_reg;
                    rec.wire_type     = hwt_reg;
                    rec.field_value   = 64'(s_data.data_byte);
                end
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_KEY;
                end
            end else if (shift_reg >= 4'd9 && s_data.data_byte > 8'd1) begin
                err_valid = 1'b1;
                err_code  = ERR_OVERFLOW;
            end else if (s_data.data_byte[7]) begin
                acc_next   = acc_new;
                shift_next = shift_reg + 4'd1;
            end else begin
                acc_next   = '0;
                shift_next = '0;
                if (phase_reg == PH_KEY) begin
                    // Field number is checked before the wire type.
                    if (acc_new[63:3] == 61'd0 || acc_new[63:32] != 32'd0) begin
                        err_valid = 1'b1;
                        err_code  = ERR_FIELD_NUM;
                    end else begin
                        hfn_next = acc_new[31:3];
                        hwt_next = acc_new[2:0];
                        case (acc_new[2:0])
                            WT_VARINT, WT_LENGTH: begin
                                phase_next = PH_VALUE;
                            end
                            WT_FIXED64, WT_FIXED32: begin
                                rem_next   = (acc_new[2:0] == WT_FIXED64) ?
                                             LENGTH_BITS'(8) : LENGTH_BITS'(4);
                                phase_next = PH_BYTES;
                                if (depth == '0) begin
                                    rec_valid        = 1'b1;
                                    rec.kind         = KIND_SIZED;
                                    rec.field_number = acc_new[31:3];
                                    rec.wire_type    = acc_new[2:0];
                                    rec.field_value  =
                                        (acc_new[2:0] == WT_FIXED64) ? 64'd8 : 64'd4;
                                end
                            end
                            WT_SGROUP: begin
                                if (CW'(depth) >= limit) begin
                                    err_valid = 1'b1;
                                    err_code  = ERR_NESTING;
                                end else begin
                                    cmd.push = 1'b1;
                                end
                            end
                            WT_EGROUP: begin
                                if (depth == '0) begin
                                    err_valid = 1'b1;
                                    err_code  = ERR_STRAY_END;
                                end else if (top != acc_new[31:3]) begin
                                    err_valid = 1'b1;
                                    err_code  = ERR_MISMATCH;
                                end else begin
                                    cmd.pop = 1'b1;
                                    if (depth == DW'(1)) begin
                                        rec_valid        = 1'b1;
                                        rec.kind         = KIND_SIZED;
                                        rec.field_number = acc_new[31:3];
                                        rec.wire_type    = WT_SGROUP;
                                        rec.field_value  = 64'd0;
                                    end
                                end
                            end
                            default: begin
                                err_valid = 1'b1;
                                err_code  = ERR_WIRE_TYPE;
                            end
                        endcase
                    end
                end else if (hwt_reg == WT_VARINT) begin
                    phase_next = PH_KEY;
                    if (depth == '0) begin
                        rec_valid        = 1'b1;
                        rec.kind         = KIND_VARINT;
                        rec.field_number = hfn_reg;
                        rec.wire_type    = WT_VARINT;
                        rec.field_value  = acc_new;
                    end
                end else if ((acc_new >> LENGTH_BITS) != 64'd0) begin
                    err_valid = 1'b1;
                    err_code  = ERR_TRUNCATED;
                end else begin
                    rem_next   = LENGTH_BITS'(acc_new);
                    phase_next = (acc_new != 64'd0) ? PH_BYTES : PH_KEY;
                    if (depth == '0) begin
                        rec_valid        = 1'b1;
                        rec.kind         = KIND_SIZED;
                        rec.field_number = hfn_reg;
                        rec.wire_type    = WT_LENGTH;
                        rec.field_value  = acc_new;
                    end
                end
            end

            // Depth once this byte's push or pop has taken effect.
            if (cmd.push) begin
                depth_after = depth + DW'(1);
            end else if (cmd.pop) begin
                depth_after = depth - DW'(1);
            end

            // A message that ends inside a field or a group is truncated.
            if (!err_valid && s_data.end_of_message &&
                (phase_next != PH_KEY || shift_next != 4'd0 || depth_after != '0)) begin
                err_valid = 1'b1;
                err_code  = ERR_TRUNCATED;
            end

            if (err_valid) begin
                tail_valid      = 1'b1;
                tail.kind       = KIND_ERROR;
                tail.error_code = err_code;
                if (!s_data.end_of_message) begin
                    latched_next = 1'b1;
                end
            end else if (s_data.end_of_message) begin
                tail_valid = 1'b1;
                tail.kind  = KIND_END;
            end
        end

        if (s_data.end_of_message) begin
            phase_next   = PH_KEY;
            acc_next     = '0;
            shift_next   = '0;
            hfn_next     = '0;
            hwt_next     = '0;
            rem_next     = '0;
            latched_next = 1'b0;
            cmd.clear    = 1'b1;
        end

        cmd.push  = cmd.push && accept;
        cmd.pop   = cmd.pop && accept;
        cmd.clear = cmd.clear && accept;
    end

    // Pack the records of this byte into the queue lanes in order.
    always_comb begin
        wr       = '0;
        wr.word0 = rec_valid ? rec : tail;
        wr.word1 = tail;
        wr.push0 = accept && (rec_valid || tail_valid);
        wr.push1 = accept && rec_valid && tail_valid;
        if (rec_valid && !tail_valid) begin
            wr.word0.last_of_run = 1'b1;
        end else if (rec_valid) begin
            wr.word1.last_of_run = 1'b1;
        end else begin
            wr.word0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_nesting_reg <= MAX_NESTING_RESET;
            phase_reg       <= PH_KEY;
            acc_reg         <= '0;
            shift_reg       <= '0;
            hfn_reg         <= '0;
            hwt_reg         <= '0;
            rem_reg         <= '0;
            latched_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_nesting_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                shift_reg   <= shift_next;
                hfn_reg     <= hfn_next;
                hwt_reg     <= hwt_next;
                rem_reg     <= rem_next;
                latched_reg <= latched_next;
            end
        end
    end

    pwft_stack #(
        .MAX_NEST (MAX_NEST),
        .DW       (DW)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .depth   (depth),
        .top     (top)
    );

    pwft_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
